// ===== rtl/gemm_pkg.sv =====
`default_nettype none

package gemm_pkg;

   typedef enum logic [1:0] {
      OP_WRITE_A = 2'd0,
      OP_WRITE_B = 2'd1,
      OP_WRITE_C = 2'd2,
      OP_COMPUTE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CSR_TRANSPOSE = 3'd0,
      CSR_ROWS_M    = 3'd1,
      CSR_COLS_K    = 3'd2,
      CSR_INNER_N   = 3'd3,
      CSR_ALPHA     = 3'd4,
      CSR_BETA      = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DOT_RD,
      ST_DOT_MUL,
      ST_DOT_ACC,
      ST_SCL_MUL,
      ST_SCL_ACC,
      ST_BETA_MUL,
      ST_BETA_ACC,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      SH_0  = 2'd0,
      SH_16 = 2'd1,
      SH_32 = 2'd2,
      SH_64 = 2'd3
   } shift_type;

   typedef struct packed {
      logic      prod_en;
      logic      acc_clr;
      logic      acc_en;
      shift_type shift;
   } mac_ctrl_type;

   localparam int OPND_W = 33;
   localparam int PROD_W = 66;
   localparam int ACC_W  = 100;
   localparam int DOT_W  = 68;

   localparam logic [31:0] ALPHA_RESET = 32'h0001_0000;
   localparam logic [31:0] SAT_POS     = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_NEG     = 32'h8000_0000;

endpackage

`default_nettype wire

// ===== rtl/gemm_mac_unit.sv =====
`default_nettype none

module gemm_mac_unit (
   input  wire                                       clock,
   input  wire                                       reset,
   input  wire gemm_pkg::mac_ctrl_type               ctrl,
   input  wire logic signed [gemm_pkg::OPND_W-1:0]   opnd_a,
   input  wire logic signed [gemm_pkg::OPND_W-1:0]   opnd_b,
   output logic signed [gemm_pkg::PROD_W-1:0]        prod,
   output logic signed [gemm_pkg::ACC_W-1:0]         acc
);

   logic signed [gemm_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [gemm_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic signed [gemm_pkg::ACC_W-1:0]  prod_ext, addend;

   always_comb begin
      prod_in  = opnd_a * opnd_b;
      prod_ext = gemm_pkg::ACC_W'(prod_ff);
      case (ctrl.shift)
         gemm_pkg::SH_0:  addend = prod_ext;
         gemm_pkg::SH_16: addend = prod_ext <<< 16;
         gemm_pkg::SH_32: addend = prod_ext <<< 32;
         gemm_pkg::SH_64: addend = prod_ext <<< 64;
         default:         addend = prod_ext;
      endcase
      acc_in = acc_ff;
      if (ctrl.acc_clr) begin
         acc_in = '0;
      end else if (ctrl.acc_en) begin
         acc_in = acc_ff + addend;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.prod_en) begin
         prod_ff <= prod_in;
      end
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign prod = prod_ff;
   assign acc  = acc_ff;

endmodule

`default_nettype wire

// ===== rtl/gemm_with_transpose_modes_core.sv =====
// Element write beats are accepted back to back while the core is idle.
// A compute beat emits m*k results; each runs a dot product over n, an alpha scaling and,
// when beta is nonzero, a beta*C term, all through one shared 33x33 multiplier and accumulator.
// The input is stalled for the whole run; a stalled output holds the sequencer.
// Synchronous reset restores the register defaults; the matrix stores are not cleared.
`default_nettype none

module gemm_with_transpose_modes_core #(
   parameter int MAX_DIM = 8
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  wire  [1:0]        req_op,
   input  wire  [5:0]        req_index,
   input  wire  [31:0]       req_value,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output logic [31:0]       rsp_result_value,
   output logic [2:0]        rsp_row,
   output logic [2:0]        rsp_col,
   output logic              rsp_last,
   input  wire               csr_valid,
   output logic              csr_ready,
   input  wire  [2:0]        csr_index,
   input  wire  [31:0]       csr_wdata
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DW    = $clog2(MAX_DIM + 1);
   localparam int PW    = 2 * DW + 1;

   logic [31:0] a_mem [DEPTH];
   logic [31:0] b_mem [DEPTH];
   logic [31:0] c_mem [DEPTH];

   gemm_pkg::state_type state_ff, state_in;

   logic [1:0]  mode_ff;
   logic [3:0]  rows_ff, cols_ff, inner_ff;
   logic [31:0] alpha_ff, beta_ff;

   logic [DW-1:0] m_ff, m_in, k_ff, k_in, n_ff, n_in;
   logic [DW-1:0] i_ff, i_in, j_ff, j_in, x_ff, x_in;
   logic [1:0]    chunk_ff, chunk_in;
   logic          ta_ff, ta_in, tb_ff, tb_in;
   logic signed [gemm_pkg::DOT_W-1:0] dot_ff, dot_in;

   logic [31:0] a_q_ff, b_q_ff, c_q_ff;
   logic [AW-1:0] a_addr, b_addr, c_addr, w_addr;
   logic [PW-1:0] a_full, b_full, c_full;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_value_ff, rsp_value_in;
   logic [2:0]    rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic          rsp_last_ff, rsp_last_in;

   gemm_pkg::mac_ctrl_type            ctrl;
   logic signed [gemm_pkg::OPND_W-1:0] opnd_a, opnd_b;
   logic signed [gemm_pkg::PROD_W-1:0] prod;
   logic signed [gemm_pkg::ACC_W-1:0]  acc;

   logic        req_take, wr_ok, emit, last_elem;
   logic [31:0] sat_value;
   logic [DW-1:0] m_cl, k_cl, n_cl;

   function automatic logic [DW-1:0] clamp_dim(input logic [3:0] v);
      logic [5:0] wide;
      wide = 6'(v);
      if (wide > 6'(MAX_DIM)) begin
         return DW'(MAX_DIM);
      end
      return DW'(v);
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= '0;
         rows_ff  <= 4'd8;
         cols_ff  <= 4'd8;
         inner_ff <= 4'd8;
         alpha_ff <= gemm_pkg::ALPHA_RESET;
         beta_ff  <= '0;
      end else if (csr_valid) begin
         case (gemm_pkg::csr_index_type'(csr_index))
            gemm_pkg::CSR_TRANSPOSE: mode_ff  <= csr_wdata[1:0];
            gemm_pkg::CSR_ROWS_M:    rows_ff  <= csr_wdata[3:0];
            gemm_pkg::CSR_COLS_K:    cols_ff  <= csr_wdata[3:0];
            gemm_pkg::CSR_INNER_N:   inner_ff <= csr_wdata[3:0];
            gemm_pkg::CSR_ALPHA:     alpha_ff <= csr_wdata;
            gemm_pkg::CSR_BETA:      beta_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_stall = (state_ff != gemm_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign wr_ok     = ({3'b000, req_index} < 9'(DEPTH));
   assign w_addr    = AW'(req_index);

   always_comb begin
      a_full = ta_ff ? (PW'(i_ff) + PW'(x_ff) * PW'(m_ff))
                     : (PW'(x_ff) + PW'(i_ff) * PW'(n_ff));
      b_full = tb_ff ? (PW'(x_ff) + PW'(j_ff) * PW'(n_ff))
                     : (PW'(j_ff) + PW'(x_ff) * PW'(k_ff));
      c_full = PW'(j_ff) + PW'(i_ff) * PW'(k_ff);
      a_addr = AW'(a_full);
      b_addr = AW'(b_full);
      c_addr = AW'(c_full);
   end

   always_ff @(posedge clock) begin
      if (req_take && wr_ok && req_op == gemm_pkg::OP_WRITE_A) begin
         a_mem[w_addr] <= req_value;
      end
      a_q_ff <= a_mem[a_addr];
   end

   always_ff @(posedge clock) begin
      if (req_take && wr_ok && req_op == gemm_pkg::OP_WRITE_B) begin
         b_mem[w_addr] <= req_value;
      end
      b_q_ff <= b_mem[b_addr];
   end

   always_ff @(posedge clock) begin
      if (req_take && wr_ok && req_op == gemm_pkg::OP_WRITE_C) begin
         c_mem[w_addr] <= req_value;
      end else if (emit) begin
         c_mem[c_addr] <= sat_value;
      end
      c_q_ff <= c_mem[c_addr];
   end

   always_comb begin
      if (acc[gemm_pkg::ACC_W-1:63] == '0 || acc[gemm_pkg::ACC_W-1:63] == '1) begin
         sat_value = acc[63:32];
      end else if (acc[gemm_pkg::ACC_W-1]) begin
         sat_value = gemm_pkg::SAT_NEG;
      end else begin
         sat_value = gemm_pkg::SAT_POS;
      end
   end

   assign m_cl      = clamp_dim(rows_ff);
   assign k_cl      = clamp_dim(cols_ff);
   assign n_cl      = clamp_dim(inner_ff);
   assign last_elem = (i_ff == m_ff - DW'(1)) && (j_ff == k_ff - DW'(1));

   always_comb begin
      state_in = state_ff;
      m_in = m_ff; k_in = k_ff; n_in = n_ff;
      i_in = i_ff; j_in = j_ff; x_in = x_ff;
      ta_in = ta_ff; tb_in = tb_ff;
      chunk_in = chunk_ff;
      dot_in = dot_ff;
      emit = 1'b0;
      ctrl = '{prod_en: 1'b0, acc_clr: 1'b0, acc_en: 1'b0, shift: gemm_pkg::SH_0};
      opnd_a = gemm_pkg::OPND_W'(signed'(a_q_ff));
      opnd_b = gemm_pkg::OPND_W'(signed'(b_q_ff));
      rsp_value_in = rsp_value_ff;
      rsp_row_in = rsp_row_ff;
      rsp_col_in = rsp_col_ff;
      rsp_last_in = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         gemm_pkg::ST_IDLE: begin
            if (req_take && req_op == gemm_pkg::OP_COMPUTE &&
                m_cl != '0 && k_cl != '0 && n_cl != '0) begin
               m_in = m_cl; k_in = k_cl; n_in = n_cl;
               ta_in = mode_ff[1];
               tb_in = mode_ff[0];
               i_in = '0; j_in = '0; x_in = '0;
               dot_in = '0;
               ctrl.acc_clr = 1'b1;
               state_in = gemm_pkg::ST_DOT_RD;
            end
         end
         gemm_pkg::ST_DOT_RD: begin
            state_in = gemm_pkg::ST_DOT_MUL;
         end
         gemm_pkg::ST_DOT_MUL: begin
            ctrl.prod_en = 1'b1;
            state_in = gemm_pkg::ST_DOT_ACC;
         end
         gemm_pkg::ST_DOT_ACC: begin
            dot_in = dot_ff + gemm_pkg::DOT_W'(prod);
            if (x_ff == n_ff - DW'(1)) begin
               x_in = '0;
               chunk_in = '0;
               state_in = gemm_pkg::ST_SCL_MUL;
            end else begin
               x_in = x_ff + DW'(1);
               state_in = gemm_pkg::ST_DOT_RD;
            end
         end
         gemm_pkg::ST_SCL_MUL: begin
            ctrl.prod_en = 1'b1;
            opnd_a = gemm_pkg::OPND_W'(signed'(alpha_ff));
            case (chunk_ff)
               2'd0:    opnd_b = {1'b0, dot_ff[31:0]};
               2'd1:    opnd_b = {1'b0, dot_ff[63:32]};
               default: opnd_b = gemm_pkg::OPND_W'(signed'(dot_ff[gemm_pkg::DOT_W-1:64]));
            endcase
            state_in = gemm_pkg::ST_SCL_ACC;
         end
         gemm_pkg::ST_SCL_ACC: begin
            ctrl.acc_en = 1'b1;
            case (chunk_ff)
               2'd0:    ctrl.shift = gemm_pkg::SH_0;
               2'd1:    ctrl.shift = gemm_pkg::SH_32;
               default: ctrl.shift = gemm_pkg::SH_64;
            endcase
            if (chunk_ff == 2'd2) begin
               state_in = (beta_ff != '0) ? gemm_pkg::ST_BETA_MUL : gemm_pkg::ST_EMIT;
            end else begin
               chunk_in = chunk_ff + 2'd1;
               state_in = gemm_pkg::ST_SCL_MUL;
            end
         end
         gemm_pkg::ST_BETA_MUL: begin
            ctrl.prod_en = 1'b1;
            opnd_a = gemm_pkg::OPND_W'(signed'(beta_ff));
            opnd_b = gemm_pkg::OPND_W'(signed'(c_q_ff));
            state_in = gemm_pkg::ST_BETA_ACC;
         end
         gemm_pkg::ST_BETA_ACC: begin
            ctrl.acc_en = 1'b1;
            ctrl.shift = gemm_pkg::SH_16;
            state_in = gemm_pkg::ST_EMIT;
         end
         gemm_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               emit = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_value_in = sat_value;
               rsp_row_in = 3'(i_ff);
               rsp_col_in = 3'(j_ff);
               rsp_last_in = last_elem;
               dot_in = '0;
               ctrl.acc_clr = 1'b1;
               if (last_elem) begin
                  state_in = gemm_pkg::ST_IDLE;
               end else begin
                  if (j_ff == k_ff - DW'(1)) begin
                     j_in = '0;
                     i_in = i_ff + DW'(1);
                  end else begin
                     j_in = j_ff + DW'(1);
                  end
                  state_in = gemm_pkg::ST_DOT_RD;
               end
            end
         end
         default: state_in = gemm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gemm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      m_ff <= m_in; k_ff <= k_in; n_ff <= n_in;
      i_ff <= i_in; j_ff <= j_in; x_ff <= x_in;
      ta_ff <= ta_in; tb_ff <= tb_in;
      chunk_ff <= chunk_in;
      dot_ff <= dot_in;
      rsp_value_ff <= rsp_value_in;
      rsp_row_ff <= rsp_row_in;
      rsp_col_ff <= rsp_col_in;
      rsp_last_ff <= rsp_last_in;
   end

   gemm_mac_unit u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .opnd_a (opnd_a),
      .opnd_b (opnd_b),
      .prod   (prod),
      .acc    (acc)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_row          = rsp_row_ff;
   assign rsp_col          = rsp_col_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/gemm_checker.sv =====
`default_nettype none

module gemm_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_stall,
   input wire [1:0]  req_op,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire [31:0] rsp_result_value,
   input wire        rsp_last
);

   // A held output beat keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_value))
      else $error("stalled result beat changed");

   // An element write never produces a result beat.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_op != gemm_pkg::OP_COMPUTE && !rsp_valid
      |=> !rsp_valid)
      else $error("result beat after element write");

   // The final beat of a run is not followed at once by another.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last |=> !rsp_valid)
      else $error("result beat directly after last");

   // Reset empties the output stage.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind gemm_with_transpose_modes_core gemm_checker u_gemm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_op           (req_op),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_result_value (rsp_result_value),
   .rsp_last         (rsp_last)
);

`default_nettype wire

// ===== tb/sv/tb_gemm_with_transpose_modes_core.sv =====
`timescale 1ns / 1ps

module tb_gemm_with_transpose_modes_core;

   localparam int DIM_MAX = 8;
   localparam int DEPTH = DIM_MAX * DIM_MAX;
   localparam logic [2:0] CSR_UNUSED = 3'd6;
   localparam logic signed [127:0] LIM_HI = 128'sh7FFF_FFFF;
   localparam logic signed [127:0] LIM_LO = -128'sh8000_0000;

   typedef struct {
      logic [31:0] value;
      logic [2:0]  row;
      logic [2:0]  col;
      logic        last;
   } elem_result_type;

   function automatic logic signed [127:0] sext(logic [31:0] v);
      return {{96{v[31]}}, v};
   endfunction

   class gemm_scoreboard;
      logic [31:0] a_mem[DEPTH];
      logic [31:0] b_mem[DEPTH];
      logic [31:0] c_mem[DEPTH];
      logic [1:0]  mode;
      logic [3:0]  dim_m, dim_k, dim_n;
      logic [31:0] alpha, beta;
      elem_result_type pending[$];
      int          errors;

      function new();
         mode = 0; dim_m = 8; dim_k = 8; dim_n = 8;
         alpha = gemm_pkg::ALPHA_RESET; beta = 0; errors = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [31:0] d);
         case (idx)
            gemm_pkg::CSR_TRANSPOSE: mode = d[1:0];
            gemm_pkg::CSR_ROWS_M:    dim_m = d[3:0];
            gemm_pkg::CSR_COLS_K:    dim_k = d[3:0];
            gemm_pkg::CSR_INNER_N:   dim_n = d[3:0];
            gemm_pkg::CSR_ALPHA:     alpha = d;
            gemm_pkg::CSR_BETA:      beta = d;
            default: ;
         endcase
      endfunction

      function void note_item(logic [1:0] op, logic [5:0] idx, logic [31:0] val);
         int m, k, n, ai, bi, ci;
         logic signed [127:0] dot, acc;
         elem_result_type r;
         case (op)
            gemm_pkg::OP_WRITE_A: a_mem[idx] = val;
            gemm_pkg::OP_WRITE_B: b_mem[idx] = val;
            gemm_pkg::OP_WRITE_C: c_mem[idx] = val;
            default: begin
               m = dim_m > DIM_MAX ? DIM_MAX : dim_m;
               k = dim_k > DIM_MAX ? DIM_MAX : dim_k;
               n = dim_n > DIM_MAX ? DIM_MAX : dim_n;
               if (m != 0 && k != 0 && n != 0) begin
                  for (int i = 0; i < m; i++) begin
                     for (int j = 0; j < k; j++) begin
                        dot = 0;
                        ci = j + i * k;
                        for (int x = 0; x < n; x++) begin
                           ai = mode[1] ? (i + x * m) : (x + i * n);
                           bi = mode[0] ? (x + j * n) : (j + x * k);
                           dot = dot + sext(a_mem[ai]) * sext(b_mem[bi]);
                        end
                        acc = sext(alpha) * dot;
                        if (beta != 0) acc = acc + ((sext(beta) * sext(c_mem[ci])) <<< 16);
                        acc = acc >>> 32;
                        if (acc > LIM_HI) c_mem[ci] = gemm_pkg::SAT_POS;
                        else if (acc < LIM_LO) c_mem[ci] = gemm_pkg::SAT_NEG;
                        else c_mem[ci] = acc[31:0];
                        r.value = c_mem[ci];
                        r.row = i[2:0];
                        r.col = j[2:0];
                        r.last = (i == m - 1) && (j == k - 1);
                        pending.push_back(r);
                     end
                  end
               end
            end
         endcase
      endfunction

      function void check_result(logic [31:0] v, logic [2:0] r, logic [2:0] c, logic l);
         elem_result_type e;
         if (pending.size() == 0) begin
            $error("unexpected result beat value=%h row=%0d col=%0d", v, r, c);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (v !== e.value) begin
            $error("result_value expected %h actual %h", e.value, v); errors++;
         end
         if (r !== e.row) begin
            $error("row expected %0d actual %0d", e.row, r); errors++;
         end
         if (c !== e.col) begin
            $error("col expected %0d actual %0d", e.col, c); errors++;
         end
         if (l !== e.last) begin
            $error("last expected %0d actual %0d", e.last, l); errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = '0;
   logic [5:0]  req_index = '0;
   logic [31:0] req_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_result_value;
   logic [2:0]  rsp_row;
   logic [2:0]  rsp_col;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   int idle_pct = 32;
   gemm_scoreboard sb;

   gemm_with_transpose_modes_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_index(req_index), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result_value(rsp_result_value), .rsp_row(rsp_row), .rsp_col(rsp_col),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_result_value, rsp_row, rsp_col, rsp_last);
      rsp_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
   end

   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic [31:0] pick_value();
      logic [31:0] v;
      case ($urandom_range(7))
         0: v = gemm_pkg::SAT_POS;
         1: v = gemm_pkg::SAT_NEG;
         2: v = '0;
         3, 4: v = $urandom_range(524288) - 262144;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic send_item(logic [1:0] op, logic [5:0] idx, logic [31:0] val);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_index <= idx;
      req_value <= val;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      sb.note_item(op, idx, val);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      sb.set_reg(idx, d);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic configure(logic [1:0] tm, logic [3:0] m, logic [3:0] k, logic [3:0] n,
                            logic [31:0] al, logic [31:0] be);
      drain();
      csr_write(gemm_pkg::CSR_TRANSPOSE, {$urandom} << 2 | tm);
      csr_write(gemm_pkg::CSR_ROWS_M, {$urandom} << 4 | m);
      csr_write(gemm_pkg::CSR_COLS_K, {$urandom} << 4 | k);
      csr_write(gemm_pkg::CSR_INNER_N, {$urandom} << 4 | n);
      csr_write(gemm_pkg::CSR_ALPHA, al);
      csr_write(gemm_pkg::CSR_BETA, be);
      if ($urandom_range(3) == 0)
         csr_write(CSR_UNUSED + 3'($urandom_range(1)), $urandom);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [3:0] pick_dim();
      case ($urandom_range(11))
         0: return 4'd0;
         1: return 4'd8;
         2: return 4'($urandom_range(9, 15));
         default: return 4'($urandom_range(1, 4));
      endcase
   endfunction

   initial begin
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every store entry gets a value before any compute can read it.
      for (int s = 0; s < 3; s++)
         for (int e = 0; e < DEPTH; e++)
            send_item(gemm_pkg::op_type'(s[1:0]), e[5:0], pick_value());

      // Saturation in both directions on a single element.
      configure(2'd0, 4'd1, 4'd1, 4'd1, gemm_pkg::SAT_POS, gemm_pkg::SAT_POS);
      send_item(gemm_pkg::OP_WRITE_A, 6'd0, gemm_pkg::SAT_POS);
      send_item(gemm_pkg::OP_WRITE_B, 6'd0, gemm_pkg::SAT_POS);
      send_item(gemm_pkg::OP_COMPUTE, 6'd63, $urandom);
      send_item(gemm_pkg::OP_WRITE_B, 6'd0, gemm_pkg::SAT_NEG);
      send_item(gemm_pkg::OP_COMPUTE, 6'd0, $urandom);
      configure(2'd0, 4'd1, 4'd1, 4'd1, gemm_pkg::SAT_NEG, gemm_pkg::SAT_NEG);
      send_item(gemm_pkg::OP_COMPUTE, 6'd0, '0);
      // Each transpose mode; beta is zero when bit 0 of the mode is set, else a random value.
      for (int t = 0; t < 4; t++) begin
         configure(t[1:0], 4'd2, 4'd3, 4'd4, pick_value(), t[0] ? 32'h0 : pick_value());
         send_item(gemm_pkg::OP_WRITE_C, 6'd1, pick_value());
         send_item(gemm_pkg::OP_COMPUTE, 6'($urandom), $urandom);
      end
      // A zero dimension yields nothing; oversized dimensions clamp.
      configure(2'd1, 4'd0, 4'd3, 4'd2, gemm_pkg::ALPHA_RESET, 32'h0);
      send_item(gemm_pkg::OP_COMPUTE, 6'd0, '0);
      configure(2'd3, 4'd15, 4'd9, 4'd12, gemm_pkg::ALPHA_RESET, 32'h0001_0000);
      send_item(gemm_pkg::OP_COMPUTE, 6'd0, '0);

      for (int p = 0; p < 11; p++) begin
         idle_pct = (p == 4) ? 0 : 32;
         configure(2'($urandom), pick_dim(), pick_dim(), pick_dim(), pick_value(),
                   $urandom_range(2) == 0 ? 32'h0 : pick_value());
         for (int q = 0; q < 8; q++) begin
            if ($urandom_range(7) == 0)
               send_item(gemm_pkg::OP_COMPUTE, 6'($urandom), $urandom);
            else
               send_item(2'($urandom_range(2)), 6'($urandom), pick_value());
         end
         send_item(gemm_pkg::OP_COMPUTE, 6'($urandom), $urandom);
      end
      idle_pct = 32;

      drain();
      if (sb.errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
